>>> design/pdll_pkg.sv
`timescale 1ns / 1ps

package pdll_pkg;

    localparam int POOL_SLOTS   = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int SLOT_W       = $clog2(POOL_SLOTS);
    localparam int LINK_W       = SLOT_W + 1;

    // A link value of POOL_SLOTS means "no slot".
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(POOL_SLOTS);

    typedef enum logic [2:0] {
        OP_ADD_FRONT  = 3'd0,
        OP_ADD_BACK   = 3'd1,
        OP_ADD_AFTER  = 3'd2,
        OP_ADD_BEFORE = 3'd3,
        OP_MOVE_FRONT = 3'd4,
        OP_READ       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADREF = 2'd2
    } t_status;

endpackage

>>> design/pdll_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module pdll_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> design/pooled_doubly_linked_list.sv
`timescale 1ns / 1ps
// A transaction accepted in idle passes through the lookup, link and fix
// states; links are written in them and the result strobe is set in fix.
// No new transaction is taken until the block is back in idle, since the
// link memories have a single read port and need up to three write passes.
// Reset is synchronous and active low; it empties the list and needs no
// clearing pass. The receiver cannot stall, so results are never held back.

// The list state lives in three RAMs (predecessor links, successor links and
// payloads). The used-slot map, head, tail and count are in flip-flops. Each
// transaction reads the reference slot's links at acceptance, then writes the
// changed links back in the lookup, link and fix states; it stays busy until
// all writes are done, so no read can overlap a pending write.
module pooled_doubly_linked_list (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            i_operation,
    input  logic [pdll_pkg::SLOT_W-1:0]           i_ref_slot,
    input  logic [pdll_pkg::PAYLOAD_BITS-1:0]     i_payload,
    output logic                                  o_done,
    output logic [1:0]                            o_status,
    output logic [pdll_pkg::SLOT_W-1:0]           o_slot_out,
    output logic [pdll_pkg::PAYLOAD_BITS-1:0]     o_read_payload,
    output logic [pdll_pkg::LINK_W-1:0]           o_read_prev,
    output logic [pdll_pkg::LINK_W-1:0]           o_read_next,
    output logic [pdll_pkg::LINK_W-1:0]           o_head_out,
    output logic [pdll_pkg::LINK_W-1:0]           o_tail_out,
    output logic [pdll_pkg::LINK_W-1:0]           o_count_out
);
    import pdll_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_LINK, S_FIX} t_state;

    t_state                  r_state;
    logic                    r_done;
    logic [POOL_SLOTS-1:0]   r_used;
    logic [LINK_W-1:0]       r_head, r_tail, r_count;

    // Per-transaction context captured at acceptance.
    t_op                     r_op;
    logic                    r_op_known;
    logic [SLOT_W-1:0]       r_ref;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [SLOT_W-1:0]       r_slot;
    t_status                 r_status;
    logic                    r_act;
    logic [LINK_W-1:0]       r_h0;
    logic [LINK_W-1:0]       r_p, r_n;
    logic [PAYLOAD_BITS-1:0] r_rd_payload;
    logic [LINK_W-1:0]       r_rd_prev, r_rd_next;

    // Registered results.
    t_status                 r_o_status;
    logic [SLOT_W-1:0]       r_o_slot;
    logic [PAYLOAD_BITS-1:0] r_o_payload;
    logic [LINK_W-1:0]       r_o_prev, r_o_next;

    logic [SLOT_W-1:0]       free_slot;
    logic [LINK_W-1:0]       prev_q, next_q;
    logic [PAYLOAD_BITS-1:0] pay_q;
    logic [LINK_W-1:0]       p_cur, n_cur;
    logic                    is_insert, is_move;
    logic                    prev_we, next_we, pay_we;
    logic [SLOT_W-1:0]       prev_waddr, next_waddr;
    logic [LINK_W-1:0]       prev_wdata, next_wdata;
    t_op                     in_op;
    logic                    in_known, in_ref_op, in_bad, in_full;
    t_status                 in_status;

    // Lowest-numbered free slot; only meaningful when the pool is not full.
    always_comb begin
        free_slot = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // Acceptance checks. A bad reference wins over a full pool.
    always_comb begin
        in_op     = t_op'(i_operation);
        in_known  = (i_operation <= 3'(OP_READ));
        in_ref_op = in_known && (i_operation >= 3'(OP_ADD_AFTER));
        in_bad    = in_ref_op && !r_used[i_ref_slot];
        in_full   = (i_operation <= 3'(OP_ADD_BEFORE)) && (r_count == LINK_W'(POOL_SLOTS));
        if (in_bad) begin
            in_status = ST_BADREF;
        end else if (in_full) begin
            in_status = ST_FULL;
        end else begin
            in_status = ST_OK;
        end
    end

    assign is_insert = r_op_known && (r_op <= OP_ADD_BEFORE);
    assign is_move   = r_op_known && (r_op == OP_MOVE_FRONT);

    // Neighbors of the position being changed. In the lookup cycle they come from
    // the RAM read data or the head or tail; later from the captured copies.
    always_comb begin
        p_cur = r_p;
        n_cur = r_n;
        if (r_state == S_LOOK) begin
            case (r_op)
                OP_ADD_FRONT: begin
                    p_cur = NONE_LINK;
                    n_cur = r_head;
                end
                OP_ADD_BACK: begin
                    p_cur = r_tail;
                    n_cur = NONE_LINK;
                end
                OP_ADD_AFTER: begin
                    p_cur = {1'b0, r_ref};
                    n_cur = next_q;
                end
                OP_ADD_BEFORE: begin
                    p_cur = prev_q;
                    n_cur = {1'b0, r_ref};
                end
                default: begin
                    p_cur = prev_q;
                    n_cur = next_q;
                end
            endcase
        end
    end

    // Link write-back schedule, at most one write per RAM per cycle.
    always_comb begin
        prev_we    = 1'b0;
        next_we    = 1'b0;
        pay_we     = 1'b0;
        prev_waddr = '0;
        next_waddr = '0;
        prev_wdata = NONE_LINK;
        next_wdata = NONE_LINK;
        if (r_act) begin
            unique case (r_state)
                S_LOOK: begin
                    if (is_insert) begin
                        // The new slot gets its own links and payload.
                        prev_we    = 1'b1;
                        prev_waddr = r_slot;
                        prev_wdata = p_cur;
                        next_we    = 1'b1;
                        next_waddr = r_slot;
                        next_wdata = n_cur;
                        pay_we     = 1'b1;
                    end else if (is_move) begin
                        // Unlink the moved slot from its neighbors.
                        next_we    = (p_cur != NONE_LINK);
                        next_waddr = p_cur[SLOT_W-1:0];
                        next_wdata = n_cur;
                        prev_we    = (n_cur != NONE_LINK);
                        prev_waddr = n_cur[SLOT_W-1:0];
                        prev_wdata = p_cur;
                    end
                end
                S_LINK: begin
                    if (is_insert) begin
                        next_we    = (p_cur != NONE_LINK);
                        next_waddr = p_cur[SLOT_W-1:0];
                        next_wdata = {1'b0, r_slot};
                        prev_we    = (n_cur != NONE_LINK);
                        prev_waddr = n_cur[SLOT_W-1:0];
                        prev_wdata = {1'b0, r_slot};
                    end else if (is_move) begin
                        prev_we    = 1'b1;
                        prev_waddr = r_ref;
                        prev_wdata = NONE_LINK;
                        next_we    = 1'b1;
                        next_waddr = r_ref;
                        next_wdata = r_h0;
                    end
                end
                S_FIX: begin
                    // The old head, which exists since it is not the moved slot.
                    if (is_move) begin
                        prev_we    = 1'b1;
                        prev_waddr = r_h0[SLOT_W-1:0];
                        prev_wdata = {1'b0, r_ref};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    pdll_ram #(.ADDR_W(SLOT_W), .DATA_W(LINK_W)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (i_ref_slot),
        .o_rdata (prev_q)
    );

    pdll_ram #(.ADDR_W(SLOT_W), .DATA_W(LINK_W)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (i_ref_slot),
        .o_rdata (next_q)
    );

    pdll_ram #(.ADDR_W(SLOT_W), .DATA_W(PAYLOAD_BITS)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (r_slot),
        .i_wdata (r_payload),
        .i_raddr (i_ref_slot),
        .o_rdata (pay_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_used  <= '0;
            r_head  <= NONE_LINK;
            r_tail  <= NONE_LINK;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op       <= in_op;
                        r_op_known <= in_known;
                        r_ref      <= i_ref_slot;
                        r_payload  <= i_payload;
                        r_slot     <= free_slot;
                        r_status   <= in_status;
                        r_h0       <= r_head;
                        // A move of the head changes nothing.
                        r_act      <= in_known && (in_status == ST_OK) &&
                                      !(in_op == OP_MOVE_FRONT &&
                                        {1'b0, i_ref_slot} == r_head);
                        r_state    <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_p          <= p_cur;
                    r_n          <= n_cur;
                    r_rd_payload <= pay_q;
                    r_rd_prev    <= prev_q;
                    r_rd_next    <= next_q;
                    r_state      <= S_LINK;
                end
                S_LINK: begin
                    if (r_act && is_insert) begin
                        r_used[r_slot] <= 1'b1;
                        r_count        <= r_count + 1'b1;
                        if (r_p == NONE_LINK) begin
                            r_head <= {1'b0, r_slot};
                        end
                        if (r_n == NONE_LINK) begin
                            r_tail <= {1'b0, r_slot};
                        end
                    end else if (r_act && is_move) begin
                        r_head <= {1'b0, r_ref};
                        if (r_n == NONE_LINK) begin
                            r_tail <= r_p;
                        end
                    end
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_o_status  <= r_status;
                    r_o_slot    <= '0;
                    r_o_payload <= '0;
                    r_o_prev    <= NONE_LINK;
                    r_o_next    <= NONE_LINK;
                    if (r_status == ST_OK && r_op_known) begin
                        if (is_insert) begin
                            r_o_slot <= r_slot;
                        end else begin
                            r_o_slot <= r_ref;
                        end
                        if (r_op == OP_READ) begin
                            r_o_payload <= r_rd_payload;
                            r_o_prev    <= r_rd_prev;
                            r_o_next    <= r_rd_next;
                        end
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_o_status;
    assign o_slot_out     = r_o_slot;
    assign o_read_payload = r_o_payload;
    assign o_read_prev    = r_o_prev;
    assign o_read_next    = r_o_next;
    assign o_head_out     = r_head;
    assign o_tail_out     = r_tail;
    assign o_count_out    = r_count;

endmodule

>>> design/pdll_checker.sv
`timescale 1ns / 1ps

module pdll_assertions (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic [5:0] o_slot_out,
    input logic [6:0] o_head_out,
    input logic [6:0] o_tail_out,
    input logic [6:0] o_count_out
);
    import pdll_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_count_out <= 7'(POOL_SLOTS))
        else $error("entry count above pool size");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_count_out == 7'd0 |->
            o_head_out == NONE_LINK && o_tail_out == NONE_LINK)
        else $error("empty list with a head or tail");

    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != 2'(ST_OK) |-> o_slot_out == '0)
        else $error("failed transaction reports a slot");

endmodule

bind pooled_doubly_linked_list pdll_assertions u_pdll_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_slot_out  (o_slot_out),
    .o_head_out  (o_head_out),
    .o_tail_out  (o_tail_out),
    .o_count_out (o_count_out)
);
